// ===== hw/rtl/c2s_pkg.sv =====
// ----------------------------------------------------------------------------
// c2s_pkg
// Shared types, constants and the arctangent table for the cartesian to
// spherical converter.
// ----------------------------------------------------------------------------
package c2s_pkg;

	localparam int COORD_WIDTH  = 16;
	localparam int CORDIC_STEPS = 16;
	localparam int FRAC_BITS    = 14;
	localparam int ANGLE_W      = 16;

	// datapath: scaled coordinate plus headroom for CORDIC gain and sign
	localparam int DATA_W = COORD_WIDTH + FRAC_BITS + 4;
	localparam int MAG_W  = DATA_W - 2;
	localparam int ANG_W  = 33;
	localparam int GAIN_W = 30;
	localparam int PROD_W = MAG_W + GAIN_W;

	localparam logic [GAIN_W-1:0] INV_GAIN = 30'd652032874;
	localparam logic [PROD_W-1:0] GAIN_ROUND = PROD_W'(64'h2000_0000);

	localparam logic signed [ANG_W-1:0] HALF_TURN    = 33'sh0_8000_0000;
	localparam logic signed [ANG_W-1:0] QUARTER_TURN = 33'sh0_4000_0000;

	// atan(2^-i) in units of 2^-32 turn
	localparam logic [31:0] ATAN_UNITS [32] = '{
		32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4,
		32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
		32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
		32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D,
		32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
		32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051,
		32'h00000029, 32'h00000014, 32'h0000000A, 32'h00000005,
		32'h00000003, 32'h00000001, 32'h00000001, 32'h00000000
	};

	typedef struct packed {
		logic signed [COORD_WIDTH-1:0] x_coord;
		logic signed [COORD_WIDTH-1:0] y_coord;
		logic signed [COORD_WIDTH-1:0] z_coord;
	} point_t;

	typedef struct packed {
		logic [COORD_WIDTH-1:0] radius;
		logic [ANGLE_W-1:0]     polar_angle;
		logic [ANGLE_W-1:0]     azimuth_angle;
	} result_t;

	typedef struct packed {
		logic signed [DATA_W-1:0] x;
		logic signed [DATA_W-1:0] y;
		logic signed [ANG_W-1:0]  ang;
	} vec_t;

	function automatic logic signed [ANG_W-1:0] atan_step(input int i);
		logic [4:0] idx;
		idx = i[4:0];
		return $signed({1'b0, ATAN_UNITS[idx]});
	endfunction

endpackage

// ===== hw/rtl/cartesian_to_spherical.sv =====
// ----------------------------------------------------------------------------
// cartesian_to_spherical
// Converts (x, y, z) to radius, polar angle and azimuth with two pipelined
// vectoring CORDIC passes and gain compensation.
// ----------------------------------------------------------------------------
//  channel   ports                 direction  transfer
//  command   start, busy, point    in         start high, busy low
//  result    done, result          out        done high, one cycle, no stall
//
//  One point per cycle. Stages in order: input register, pass one,
//  two-stage compensation, pass two set-up, pass two, two-stage
//  compensation, output register.
//  busy is held low: every stage advances every cycle.
//  Reset clears the valid bits only; datapath registers are not reset.
// ----------------------------------------------------------------------------
module cartesian_to_spherical (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	output logic             busy,
	input  c2s_pkg::point_t  point,
	output logic             done,
	output c2s_pkg::result_t result
);

	localparam int CW = c2s_pkg::COORD_WIDTH;
	localparam int DW = c2s_pkg::DATA_W;
	localparam int MW = c2s_pkg::MAG_W;
	localparam int AW = c2s_pkg::ANG_W;
	localparam int OW = c2s_pkg::ANGLE_W;
	localparam int SIDE1_LEN = c2s_pkg::CORDIC_STEPS + 2;
	localparam int SIDE2_LEN = c2s_pkg::CORDIC_STEPS + 2;

	typedef struct packed {
		logic                 special;
		logic signed [CW-1:0] z;
	} side1_t;

	typedef struct packed {
		logic          special;
		logic          zneg;
		logic [CW-1:0] absz;
		logic [OW-1:0] azim;
	} side2_t;

	assign busy = 1'b0;

	// ---- input stage: pre-rotate negative x by pi
	logic signed [DW-1:0] px, py;
	c2s_pkg::vec_t        vec_in;
	c2s_pkg::vec_t        vec_s1;
	side1_t               side_s1;
	logic                 valid_s1;

	always_comb begin
		px = $signed({{(DW-CW){point.x_coord[CW-1]}}, point.x_coord}) <<< c2s_pkg::FRAC_BITS;
		py = $signed({{(DW-CW){point.y_coord[CW-1]}}, point.y_coord}) <<< c2s_pkg::FRAC_BITS;
		if (point.x_coord[CW-1]) begin
			vec_in.x   = -px;
			vec_in.y   = -py;
			vec_in.ang = c2s_pkg::HALF_TURN;
		end else begin
			vec_in.x   = px;
			vec_in.y   = py;
			vec_in.ang = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= start & ~busy;
		end
	end

	always_ff @(posedge clk) begin
		vec_s1          <= vec_in;
		side_s1.special <= (point.x_coord == '0) && (point.y_coord == '0);
		side_s1.z       <= point.z_coord;
	end

	// ---- pass one on (x, y)
	logic          p1_valid;
	c2s_pkg::vec_t p1_vec;

	c2s_vector_pass u_pass1 (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (valid_s1),
		.in_vec    (vec_s1),
		.out_valid (p1_valid),
		.out_vec   (p1_vec)
	);

	logic          c1_valid;
	logic [MW-1:0] rho;

	c2s_gain_comp u_comp1 (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (p1_valid),
		.mag       (p1_vec.x[MW-1:0]),
		.out_valid (c1_valid),
		.comp_mag  (rho)
	);

	// azimuth rounds from the low 32 bits, wrapping a full turn
	logic [31:0]   az_sum;
	logic [OW-1:0] az_d1_q, az_d2_q;

	assign az_sum = p1_vec.ang[31:0] + 32'h0000_8000;

	always_ff @(posedge clk) begin
		az_d1_q <= az_sum[31:16];
		az_d2_q <= az_d1_q;
	end

	side1_t side1_pipe_q [SIDE1_LEN];

	always_ff @(posedge clk) begin
		side1_pipe_q[0] <= side_s1;
		for (int k = 1; k < SIDE1_LEN; k++) begin
			side1_pipe_q[k] <= side1_pipe_q[k-1];
		end
	end

	// ---- pass two set-up: (z, rho), negative z pre-rotated by -pi/2
	side1_t               side1_out;
	logic signed [DW-1:0] qz, qrho;
	c2s_pkg::vec_t        vec2_in;
	c2s_pkg::vec_t        vec_s2;
	side2_t               side_s2;
	logic                 valid_s2;

	always_comb begin
		side1_out = side1_pipe_q[SIDE1_LEN-1];
		qz   = $signed({{(DW-CW){side1_out.z[CW-1]}}, side1_out.z}) <<< c2s_pkg::FRAC_BITS;
		qrho = $signed({{(DW-MW){1'b0}}, rho});
		if (side1_out.z[CW-1]) begin
			vec2_in.x   = qrho;
			vec2_in.y   = -qz;
			vec2_in.ang = c2s_pkg::QUARTER_TURN;
		end else begin
			vec2_in.x   = qz;
			vec2_in.y   = qrho;
			vec2_in.ang = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else begin
			valid_s2 <= c1_valid;
		end
	end

	always_ff @(posedge clk) begin
		vec_s2          <= vec2_in;
		side_s2.special <= side1_out.special;
		side_s2.zneg    <= side1_out.z[CW-1];
		side_s2.absz    <= side1_out.z[CW-1] ? CW'(-side1_out.z) : CW'(side1_out.z);
		side_s2.azim    <= az_d2_q;
	end

	// ---- pass two on (z, rho)
	logic          p2_valid;
	c2s_pkg::vec_t p2_vec;

	c2s_vector_pass u_pass2 (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (valid_s2),
		.in_vec    (vec_s2),
		.out_valid (p2_valid),
		.out_vec   (p2_vec)
	);

	logic          c2_valid;
	logic [MW-1:0] rfix;

	c2s_gain_comp u_comp2 (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (p2_valid),
		.mag       (p2_vec.x[MW-1:0]),
		.out_valid (c2_valid),
		.comp_mag  (rfix)
	);

	// polar angle: clamp to [0, pi], then round
	logic signed [AW-1:0] b_clamp;
	logic [AW-1:0]        b_sum;
	logic [OW-1:0]        polar_d1_q, polar_d2_q;

	always_comb begin
		if (p2_vec.ang[AW-1]) begin
			b_clamp = '0;
		end else if (p2_vec.ang > c2s_pkg::HALF_TURN) begin
			b_clamp = c2s_pkg::HALF_TURN;
		end else begin
			b_clamp = p2_vec.ang;
		end
		b_sum = b_clamp + AW'(32'h0000_8000);
	end

	always_ff @(posedge clk) begin
		polar_d1_q <= b_sum[OW+15:16];
		polar_d2_q <= polar_d1_q;
	end

	side2_t side2_pipe_q [SIDE2_LEN];

	always_ff @(posedge clk) begin
		side2_pipe_q[0] <= side_s2;
		for (int k = 1; k < SIDE2_LEN; k++) begin
			side2_pipe_q[k] <= side2_pipe_q[k-1];
		end
	end

	// ---- output stage
	side2_t        side2_out;
	logic [MW:0]   r_sum;
	logic [MW-c2s_pkg::FRAC_BITS:0] r_round;
	logic [CW-1:0] r_sat;
	c2s_pkg::result_t res_d;
	c2s_pkg::result_t result_q;
	logic          done_q;

	always_comb begin
		side2_out = side2_pipe_q[SIDE2_LEN-1];
		r_sum     = {1'b0, rfix} + (MW+1)'(1 << (c2s_pkg::FRAC_BITS - 1));
		r_round   = r_sum[MW:c2s_pkg::FRAC_BITS];
		if (r_round > (MW-c2s_pkg::FRAC_BITS+1)'({CW{1'b1}})) begin
			r_sat = '1;
		end else begin
			r_sat = r_round[CW-1:0];
		end
		if (side2_out.special) begin
			// on the z axis: plain |z|, angle 0 or pi, no azimuth
			res_d.radius        = side2_out.absz;
			res_d.polar_angle   = side2_out.zneg ? OW'(32768) : '0;
			res_d.azimuth_angle = '0;
		end else begin
			res_d.radius        = r_sat;
			res_d.polar_angle   = polar_d2_q;
			res_d.azimuth_angle = side2_out.azim;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= c2_valid;
		end
	end

	always_ff @(posedge clk) begin
		result_q <= res_d;
	end

	assign done   = done_q;
	assign result = result_q;

endmodule

// ===== hw/rtl/c2s_vector_pass.sv =====
// ----------------------------------------------------------------------------
// c2s_vector_pass
// Vectoring CORDIC, one micro-rotation per pipeline stage. Drives y toward
// zero and accumulates the rotation angle.
// ----------------------------------------------------------------------------
module c2s_vector_pass (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	input  c2s_pkg::vec_t    in_vec,
	output logic             out_valid,
	output c2s_pkg::vec_t    out_vec
);

	c2s_pkg::vec_t stage_vec_s   [c2s_pkg::CORDIC_STEPS+1];
	logic          stage_valid_s [c2s_pkg::CORDIC_STEPS+1];

	assign stage_vec_s[0]   = in_vec;
	assign stage_valid_s[0] = in_valid;

	for (genvar i = 0; i < c2s_pkg::CORDIC_STEPS; i++) begin : g_step
		logic signed [c2s_pkg::DATA_W-1:0] cur_x, cur_y, dx, dy;
		logic signed [c2s_pkg::ANG_W-1:0]  cur_ang, step_ang;
		c2s_pkg::vec_t                     nxt;

		always_comb begin
			cur_x    = stage_vec_s[i].x;
			cur_y    = stage_vec_s[i].y;
			cur_ang  = stage_vec_s[i].ang;
			// arithmetic shift is the floor shift
			dx       = cur_y >>> i;
			dy       = cur_x >>> i;
			step_ang = c2s_pkg::atan_step(i);
			if (!cur_y[c2s_pkg::DATA_W-1]) begin
				nxt.x   = cur_x + dx;
				nxt.y   = cur_y - dy;
				nxt.ang = cur_ang + step_ang;
			end else begin
				nxt.x   = cur_x - dx;
				nxt.y   = cur_y + dy;
				nxt.ang = cur_ang - step_ang;
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				stage_valid_s[i+1] <= 1'b0;
			end else begin
				stage_valid_s[i+1] <= stage_valid_s[i];
			end
		end

		always_ff @(posedge clk) begin
			stage_vec_s[i+1] <= nxt;
		end
	end

	assign out_valid = stage_valid_s[c2s_pkg::CORDIC_STEPS];
	assign out_vec   = stage_vec_s[c2s_pkg::CORDIC_STEPS];

endmodule

// ===== hw/rtl/c2s_gain_comp.sv =====
// ----------------------------------------------------------------------------
// c2s_gain_comp
// CORDIC gain compensation: multiply by 1/K in Q30, round half up.
// Two stages, product then rounding shift.
// ----------------------------------------------------------------------------
module c2s_gain_comp (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       in_valid,
	input  logic [c2s_pkg::MAG_W-1:0]  mag,
	output logic                       out_valid,
	output logic [c2s_pkg::MAG_W-1:0]  comp_mag
);

	logic [c2s_pkg::PROD_W-1:0] prod_s1;
	logic [c2s_pkg::PROD_W-1:0] rounded;
	logic [c2s_pkg::MAG_W-1:0]  comp_s2;
	logic                       valid_s1, valid_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			valid_s1 <= in_valid;
			valid_s2 <= valid_s1;
		end
	end

	assign rounded = prod_s1 + c2s_pkg::GAIN_ROUND;

	always_ff @(posedge clk) begin
		prod_s1 <= c2s_pkg::PROD_W'(mag) * c2s_pkg::PROD_W'(c2s_pkg::INV_GAIN);
		comp_s2 <= rounded[c2s_pkg::PROD_W-1:c2s_pkg::GAIN_W];
	end

	assign out_valid = valid_s2;
	assign comp_mag  = comp_s2;

endmodule
